FILE: rtl/core/tps_pkg.sv
// Shared types and constants for the temperature profile sequencer.
`default_nettype none
package tps_pkg;

	localparam int STEP_DEPTH_DEF = 16;
	localparam int NUM_W          = 5;
	localparam int TEMP_W         = 7;
	localparam int MIN_W          = 16;
	localparam int MEAS_W         = 12;
	localparam int ELAPSED_W      = 16;
	localparam int DWELL_W        = 32;
	localparam int TICK_W         = 8;
	localparam int LIMIT_W        = 32;

	localparam logic [LIMIT_W-1:0] MS_PER_MIN    = LIMIT_W'(60 * 1000);
	localparam logic [TICK_W-1:0]  ON_LIMIT_RST  = 8'd3;
	localparam logic [TICK_W-1:0]  OFF_LIMIT_RST = 8'd8;
	localparam logic [TICK_W-1:0]  TICK_MAX      = 8'hFF;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_ADD    = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_UPDATE = 3'd3,
		CMD_GOTO   = 3'd4,
		CMD_HALT   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic {
		CFG_ON_LIMIT  = 1'b0,
		CFG_OFF_LIMIT = 1'b1
	} cfg_reg_t;

	// One profile step; the hold time is kept already scaled to milliseconds.
	typedef struct packed {
		logic [TEMP_W-1:0]  temp;
		logic [LIMIT_W-1:0] limit_ms;
		logic               wait_cfm;
		logic               hold_zero;
	} step_entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/tps_step_mem.sv
// Step table: one write port, two registered read ports with write bypass.
`default_nettype none
module tps_step_mem
	import tps_pkg::*;
#(
	parameter int DEPTH = STEP_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [AW-1:0] waddr,
	input  wire step_entry_t wdata,
	input  wire logic [AW-1:0] raddr_a,
	input  wire logic [AW-1:0] raddr_b,
	output step_entry_t      rdata_a,
	output step_entry_t      rdata_b
);

	step_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Pass a same-cycle write straight through so the next word sees it.
	always_ff @(posedge clk) begin
		rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
		rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
	end

endmodule
`default_nettype wire

FILE: rtl/core/temperature_profile_sequencer.sv
// Top level of the temperature profile sequencer: command decode, heater and dwell logic.
// An accepted word passes the input stage and then the result register, which raises done.
// Throughput: one word per cycle; busy stays low, start is taken on every edge it is high.
// Each result is shown for exactly one cycle; the receiver cannot stall it.
// The step table is read through registered ports, so its current entry is fetched ahead of the word.
// Reset (arst_n low, asynchronous) clears step count, run state and counters, and presets limits.
`default_nettype none
module temperature_profile_sequencer
	import tps_pkg::*;
#(
	parameter int STEP_DEPTH = STEP_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// command word
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [2:0]                  cmd,
	input  wire logic [NUM_W-1:0]            step_number,
	input  wire logic [TEMP_W-1:0]           step_temp,
	input  wire logic [MIN_W-1:0]            step_minutes,
	input  wire logic                        step_wait,
	input  wire logic                        step_hold,
	input  wire logic signed [MEAS_W-1:0]    temperature,
	input  wire logic [ELAPSED_W-1:0]        elapsed_ms,
	input  wire logic                        confirm,
	// configuration write port
	input  wire logic                        cfg_write,
	input  wire logic                        cfg_index,
	input  wire logic [TICK_W-1:0]           cfg_data,
	// result word
	output logic                             done,
	output logic                             heater_on,
	output logic                             in_band,
	output logic [NUM_W-1:0]                 current_index,
	output logic                             awaiting,
	output logic                             finished,
	output logic                             active,
	output logic [1:0]                       status
);

	localparam int AW    = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
	localparam int CNT_W = $clog2(STEP_DEPTH + 1);
	localparam int RI_W  = $clog2(STEP_DEPTH + 2);
	localparam int CMP_W = (RI_W > NUM_W) ? RI_W : NUM_W;

	// ---------------------------------------------------------------------
	// Input stage: capture the word; scale the hold time to ms on the way in.
	// ---------------------------------------------------------------------
	logic                       valid_s1;
	cmd_t                       cmd_s1;
	logic [NUM_W-1:0]           number_s1;
	logic [TEMP_W-1:0]          temp_s1;
	logic [LIMIT_W-1:0]         limit_s1;
	logic                       wait_s1;
	logic                       hold_s1;
	logic signed [MEAS_W-1:0]   meas_s1;
	logic [ELAPSED_W-1:0]       elapsed_s1;
	logic                       confirm_s1;
	logic                       accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_t'(cmd);
			number_s1  <= step_number;
			temp_s1    <= step_temp;
			limit_s1   <= LIMIT_W'(step_minutes) * MS_PER_MIN;
			wait_s1    <= step_wait;
			hold_s1    <= step_hold;
			meas_s1    <= temperature;
			elapsed_s1 <= elapsed_ms;
			confirm_s1 <= confirm;
		end
	end

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [TICK_W-1:0] on_limit_q;
	logic [TICK_W-1:0] off_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_limit_q  <= ON_LIMIT_RST;
			off_limit_q <= OFF_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ON_LIMIT:  on_limit_q  <= cfg_data;
				CFG_OFF_LIMIT: off_limit_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Profile state
	// ---------------------------------------------------------------------
	logic [CNT_W-1:0]   count_q, count_d;
	logic [RI_W-1:0]    ri_q, ri_d;
	logic [DWELL_W-1:0] dwell_q, dwell_d;
	logic [TICK_W-1:0]  on_q, on_d;
	logic [TICK_W-1:0]  off_q, off_d;
	logic               wait_q, wait_d;
	logic               run_q, run_d;
	logic               heater_q, heater_d;

	// Step table
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	step_entry_t mem_wdata;
	logic [AW-1:0] raddr_a, raddr_b;
	step_entry_t rd_a, rd_b;
	logic [RI_W-1:0]  ri_prev;
	logic [CMP_W-1:0] num_b_prev;

	// Port A follows the running step as it will be after this word;
	// port B fetches the entry a start-at word names while the word is still at the input.
	assign ri_prev    = ri_d - RI_W'(1);
	assign raddr_a    = ri_prev[AW-1:0];
	assign num_b_prev = CMP_W'(step_number) - CMP_W'(1);
	assign raddr_b    = num_b_prev[AW-1:0];

	tps_step_mem #(
		.DEPTH (STEP_DEPTH),
		.AW    (AW)
	) u_step_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// ---------------------------------------------------------------------
	// Command decode and tick logic
	// ---------------------------------------------------------------------
	logic [CMP_W-1:0]       num_ext;
	logic [CMP_W-1:0]       num_prev;
	logic [CMP_W-1:0]       count_ext;
	logic                   idx_ok;
	status_t                status_d;
	logic                   band_d;
	logic                   do_tick;
	logic                   use_b;
	logic [RI_W-1:0]        ri_t;
	logic [DWELL_W-1:0]     dwell_t;
	logic                   wait_t;
	logic                   run_t;
	step_entry_t            ent;
	logic                   hold_wait;
	logic [TEMP_W-1:0]      target;
	logic signed [13:0]     meas_x;
	logic signed [13:0]     tgt16;
	logic signed [13:0]     band_lo;
	logic signed [13:0]     band_hi;
	logic [TICK_W-1:0]      off_inc;
	logic [DWELL_W:0]       dwell_sum;
	logic [DWELL_W-1:0]     dwell_sat;

	assign num_ext   = CMP_W'(number_s1);
	assign num_prev  = num_ext - CMP_W'(1);
	assign count_ext = CMP_W'(count_q);
	assign idx_ok    = (num_ext != '0) && (num_ext <= count_ext);

	assign mem_wdata.temp      = temp_s1;
	assign mem_wdata.limit_ms  = limit_s1;
	assign mem_wdata.wait_cfm  = wait_s1;
	assign mem_wdata.hold_zero = hold_s1;

	always_comb begin
		count_d   = count_q;
		ri_d      = ri_q;
		dwell_d   = dwell_q;
		on_d      = on_q;
		off_d     = off_q;
		wait_d    = wait_q;
		run_d     = run_q;
		heater_d  = heater_q;
		status_d  = ST_OK;
		band_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		do_tick   = 1'b0;
		use_b     = 1'b0;
		ri_t      = ri_q;
		dwell_t   = dwell_q;
		wait_t    = wait_q;
		run_t     = run_q;

		if (valid_s1) begin
			unique case (cmd_s1)
				CMD_TICK: begin
					do_tick = 1'b1;
				end
				CMD_ADD: begin
					if (count_q == CNT_W'(STEP_DEPTH)) begin
						status_d = ST_FULL;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				CMD_DELETE: begin
					// the dropped entry is never read again before a fresh add
					if (count_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						count_d = count_q - CNT_W'(1);
					end
				end
				CMD_UPDATE: begin
					if (!idx_ok) begin
						status_d = (count_q == '0) ? ST_EMPTY : ST_BAD_INDEX;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = num_prev[AW-1:0];
					end
				end
				CMD_GOTO: begin
					if (!idx_ok) begin
						status_d = (count_q == '0) ? ST_EMPTY : ST_BAD_INDEX;
						run_d    = 1'b0;
						heater_d = 1'b0;
					end else begin
						do_tick = 1'b1;
						use_b   = 1'b1;
						ri_t    = RI_W'(num_ext);
						dwell_t = '0;
						wait_t  = 1'b0;
						run_t   = 1'b1;
					end
				end
				CMD_HALT: begin
					run_d    = 1'b0;
					wait_d   = 1'b0;
					dwell_d  = '0;
					heater_d = 1'b0;
				end
				default: ;
			endcase
		end

		// Tick datapath
		ent       = use_b ? rd_b : rd_a;
		hold_wait = ent.hold_zero && wait_t;
		target    = hold_wait ? '0 : ent.temp;
		meas_x    = 14'(meas_s1);
		tgt16     = $signed({3'b000, target, 4'b0000});
		band_lo   = tgt16 - 14'sd16;
		band_hi   = tgt16 + 14'sd160;
		off_inc   = (off_q != TICK_MAX) ? off_q + TICK_W'(1) : off_q;
		dwell_sum = {1'b0, dwell_t} + (DWELL_W + 1)'(elapsed_s1);
		dwell_sat = dwell_sum[DWELL_W] ? '1 : dwell_sum[DWELL_W-1:0];

		if (do_tick) begin
			if (!run_t || ri_t == '0 || ri_t > RI_W'(count_q)) begin
				run_d    = 1'b0;
				heater_d = 1'b0;
			end else begin
				ri_d    = ri_t;
				dwell_d = dwell_t;
				wait_d  = wait_t;
				run_d   = run_t;

				// bang-bang drive with a cap on on ticks, cleared once the off count reaches its limit
				if (meas_x <= tgt16 && on_q < on_limit_q) begin
					heater_d = 1'b1;
					on_d     = on_q + TICK_W'(1);
					off_d    = '0;
				end else begin
					heater_d = 1'b0;
					off_d    = off_inc;
					if (off_inc >= off_limit_q) begin
						on_d = '0;
					end
				end
				band_d = (meas_x >= band_lo) && (meas_x <= band_hi);

				if (hold_wait) begin
					if (confirm_s1) begin
						ri_d    = ri_t + RI_W'(1);
						dwell_d = '0;
						wait_d  = 1'b0;
					end
				end else if (band_d) begin
					dwell_d = dwell_sat;
					if (dwell_sat > ent.limit_ms) begin
						if (!ent.wait_cfm || confirm_s1) begin
							ri_d    = ri_t + RI_W'(1);
							dwell_d = '0;
							wait_d  = 1'b0;
						end else begin
							wait_d = 1'b1;
						end
					end
				end

				// past the last step: drop out of the run
				if (ri_d > RI_W'(count_q)) begin
					run_d    = 1'b0;
					heater_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ri_q     <= RI_W'(1);
			dwell_q  <= '0;
			on_q     <= '0;
			off_q    <= '0;
			wait_q   <= 1'b0;
			run_q    <= 1'b0;
			heater_q <= 1'b0;
		end else begin
			count_q  <= count_d;
			ri_q     <= ri_d;
			dwell_q  <= dwell_d;
			on_q     <= on_d;
			off_q    <= off_d;
			wait_q   <= wait_d;
			run_q    <= run_d;
			heater_q <= heater_d;
		end
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	logic [CMP_W-1:0] ri_out;
	logic             done_q;
	logic             band_q;
	logic [NUM_W-1:0] index_q;
	logic             finished_q;
	status_t          status_q;

	assign ri_out = CMP_W'(ri_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			band_q     <= band_d;
			index_q    <= ri_out[NUM_W-1:0];
			finished_q <= ri_d > RI_W'(count_d);
			status_q   <= status_d;
		end
	end

	assign done          = done_q;
	assign heater_on     = heater_q;
	assign in_band       = band_q;
	assign current_index = index_q;
	assign awaiting      = wait_q;
	assign finished      = finished_q;
	assign active        = run_q;
	assign status        = status_q;

`ifndef ASSERT_OFF
	// every accepted word gives exactly one result, in the cycle after its input stage
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done_q == $past(valid_s1))
		else $error("result strobe out of step with the input stage");

	// the heater is only driven while a profile runs
	a_heater_run: assert property (@(posedge clk) disable iff (!arst_n)
		heater_q |-> run_q)
		else $error("heater on with no profile running");

	// the band flag comes only from words that ran a tick
	a_band_tick: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && band_d |-> (cmd_s1 == CMD_TICK || cmd_s1 == CMD_GOTO))
		else $error("band flag raised by a word that ran no tick");
`endif

endmodule
`default_nettype wire

FILE: tb/temperature_profile_sequencer_checker.sv
// Checker for the temperature profile sequencer: predicts each readout and compares it.
module temperature_profile_sequencer_checker
	import tps_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [2:0]               cmd,
	input  logic [NUM_W-1:0]         step_number,
	input  logic [TEMP_W-1:0]        step_temp,
	input  logic [MIN_W-1:0]         step_minutes,
	input  logic                     step_wait,
	input  logic                     step_hold,
	input  logic signed [MEAS_W-1:0] temperature,
	input  logic [ELAPSED_W-1:0]     elapsed_ms,
	input  logic                     confirm,
	input  logic                     cfg_write,
	input  logic                     cfg_index,
	input  logic [TICK_W-1:0]        cfg_data,
	input  logic                     done,
	input  logic                     heater_on,
	input  logic                     in_band,
	input  logic [NUM_W-1:0]         current_index,
	input  logic                     awaiting,
	input  logic                     finished,
	input  logic                     active,
	input  logic [1:0]               status,
	output int unsigned              fault_count,
	output int unsigned              words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BAND_BELOW = 1;
	localparam int BAND_ABOVE = 10;

	typedef struct packed {
		logic             heater_on;
		logic             in_band;
		logic [NUM_W-1:0] index;
		logic             awaiting;
		logic             finished;
		logic             active;
		status_t          status;
	} readout_t;

	// shadow of the block's step table and run state
	logic [TEMP_W-1:0]  tbl_temp    [STEP_DEPTH_DEF];
	logic [MIN_W-1:0]   tbl_minutes [STEP_DEPTH_DEF];
	logic               tbl_ask     [STEP_DEPTH_DEF];
	logic               tbl_drop    [STEP_DEPTH_DEF];
	int unsigned        n_steps = 0;
	int unsigned        run_idx = 1;
	logic [DWELL_W-1:0] dwell   = '0;
	logic [TICK_W-1:0]  on_cnt  = '0;
	logic [TICK_W-1:0]  off_cnt = '0;
	logic [TICK_W-1:0]  on_max  = ON_LIMIT_RST;
	logic [TICK_W-1:0]  off_max = OFF_LIMIT_RST;
	logic               waiting = 1'b0;
	logic               running = 1'b0;
	logic               heat    = 1'b0;

	readout_t readouts_due[$];

	initial begin
		fault_count = 0;
		words_due   = 0;
	end

	function automatic void next_step();
		run_idx++;
		dwell   = '0;
		waiting = 1'b0;
	endfunction

	// bang-bang decision with on/off tick limits; returns the band test
	function automatic logic regulate_heat(int t16, int target);
		if (t16 <= target * 16 && on_cnt < on_max) begin
			heat    = 1'b1;
			on_cnt  = on_cnt + 1'b1;
			off_cnt = '0;
		end else begin
			heat = 1'b0;
			if (off_cnt != TICK_MAX)
				off_cnt = off_cnt + 1'b1;
			if (off_cnt >= off_max)
				on_cnt = '0;
		end
		return t16 >= (target - BAND_BELOW) * 16 && t16 <= (target + BAND_ABOVE) * 16;
	endfunction

	function automatic logic run_tick(int t16, logic [ELAPSED_W-1:0] ms, logic yes);
		logic               band;
		int unsigned        i;
		logic [LIMIT_W-1:0] limit;
		logic [DWELL_W:0]   sum;
		band = 1'b0;
		if (!running || run_idx < 1 || run_idx > n_steps) begin
			running = 1'b0;
			heat    = 1'b0;
			return 1'b0;
		end
		i = run_idx - 1;
		if (tbl_drop[i] && waiting) begin
			// hold wait: regulate towards zero, a confirm moves on
			band = regulate_heat(t16, 0);
			if (yes)
				next_step();
		end else begin
			band = regulate_heat(t16, int'(tbl_temp[i]));
			if (band) begin
				limit = LIMIT_W'(tbl_minutes[i]) * MS_PER_MIN;
				sum   = dwell + ms;
				dwell = sum[DWELL_W] ? '1 : sum[DWELL_W-1:0];
				if (dwell > limit) begin
					if (!tbl_ask[i] || yes)
						next_step();
					else
						waiting = 1'b1;
				end
			end
		end
		if (run_idx > n_steps) begin
			running = 1'b0;
			heat    = 1'b0;
		end
		return band;
	endfunction

	function automatic readout_t apply_word(logic [2:0] op, logic [NUM_W-1:0] num,
			logic [TEMP_W-1:0] deg, logic [MIN_W-1:0] mins, logic ask, logic drop,
			logic signed [MEAS_W-1:0] meas, logic [ELAPSED_W-1:0] ms, logic yes);
		readout_t r;
		int       t16;
		logic     band;
		logic     idx_ok;
		status_t  st;
		t16    = meas;
		band   = 1'b0;
		st     = ST_OK;
		idx_ok = num >= 1 && num <= n_steps;
		case (op)
			CMD_TICK: band = run_tick(t16, ms, yes);
			CMD_ADD: begin
				if (n_steps >= STEP_DEPTH_DEF) begin
					st = ST_FULL;
				end else begin
					tbl_temp[n_steps]    = deg;
					tbl_minutes[n_steps] = mins;
					tbl_ask[n_steps]     = ask;
					tbl_drop[n_steps]    = drop;
					n_steps++;
				end
			end
			CMD_DELETE: begin
				if (n_steps == 0) begin
					st = ST_EMPTY;
				end else begin
					n_steps--;
					tbl_temp[n_steps]    = '0;
					tbl_minutes[n_steps] = '0;
					tbl_ask[n_steps]     = 1'b0;
					tbl_drop[n_steps]    = 1'b0;
				end
			end
			CMD_UPDATE: begin
				if (!idx_ok) begin
					st = (n_steps == 0) ? ST_EMPTY : ST_BAD_INDEX;
				end else begin
					tbl_temp[num-1]    = deg;
					tbl_minutes[num-1] = mins;
					tbl_ask[num-1]     = ask;
					tbl_drop[num-1]    = drop;
				end
			end
			CMD_GOTO: begin
				if (!idx_ok) begin
					st      = (n_steps == 0) ? ST_EMPTY : ST_BAD_INDEX;
					running = 1'b0;
					heat    = 1'b0;
				end else begin
					run_idx = num;
					dwell   = '0;
					waiting = 1'b0;
					running = 1'b1;
					band    = run_tick(t16, ms, yes);
				end
			end
			CMD_HALT: begin
				running = 1'b0;
				waiting = 1'b0;
				dwell   = '0;
				heat    = 1'b0;
			end
			default: ;
		endcase
		r.heater_on = heat;
		r.in_band   = band;
		r.index     = run_idx[NUM_W-1:0];
		r.awaiting  = waiting;
		r.finished  = run_idx > n_steps;
		r.active    = running;
		r.status    = st;
		return r;
	endfunction

	task automatic check_field(string label, logic [NUM_W-1:0] want, logic [NUM_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", label, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		readout_t want;
		if (!arst_n) begin
			n_steps = 0;
			run_idx = 1;
			dwell   = '0;
			on_cnt  = '0;
			off_cnt = '0;
			on_max  = ON_LIMIT_RST;
			off_max = OFF_LIMIT_RST;
			waiting = 1'b0;
			running = 1'b0;
			heat    = 1'b0;
			readouts_due.delete();
			words_due = 0;
		end else begin
			if (done) begin
				if (readouts_due.size() == 0) begin
					$error("readout with no word outstanding");
					fault_count++;
				end else begin
					want = readouts_due.pop_front();
					check_field("heater_on", NUM_W'(want.heater_on), NUM_W'(heater_on));
					check_field("in_band", NUM_W'(want.in_band), NUM_W'(in_band));
					check_field("current_index", want.index, current_index);
					check_field("awaiting", NUM_W'(want.awaiting), NUM_W'(awaiting));
					check_field("finished", NUM_W'(want.finished), NUM_W'(finished));
					check_field("active", NUM_W'(want.active), NUM_W'(active));
					check_field("status", NUM_W'(want.status), NUM_W'(status));
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_ON_LIMIT:  on_max = cfg_data;
					CFG_OFF_LIMIT: off_max = cfg_data;
				endcase
			end
			if (start && !busy)
				readouts_due.push_back(apply_word(cmd, step_number, step_temp, step_minutes,
					step_wait, step_hold, temperature, elapsed_ms, confirm));
			words_due = readouts_due.size();
		end
	end

endmodule

FILE: tb/temperature_profile_sequencer_test.sv
// Testbench top for the temperature profile sequencer: stimulus, watchdog and verdict.
module temperature_profile_sequencer_test;
	import tps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no word taken and no readout before the run is called hung
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_WORDS = 150;
	localparam int NUM_PHASES  = 6;

	typedef struct packed {
		logic [2:0]               op;
		logic [NUM_W-1:0]         num;
		logic [TEMP_W-1:0]        deg;
		logic [MIN_W-1:0]         mins;
		logic                     ask;
		logic                     drop;
		logic signed [MEAS_W-1:0] meas;
		logic [ELAPSED_W-1:0]     ms;
		logic                     yes;
	} word_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     start        = 1'b0;
	logic [2:0]               cmd          = CMD_TICK;
	logic [NUM_W-1:0]         step_number  = '0;
	logic [TEMP_W-1:0]        step_temp    = '0;
	logic [MIN_W-1:0]         step_minutes = '0;
	logic                     step_wait    = 1'b0;
	logic                     step_hold    = 1'b0;
	logic signed [MEAS_W-1:0] temperature  = '0;
	logic [ELAPSED_W-1:0]     elapsed_ms   = '0;
	logic                     confirm      = 1'b0;
	logic                     cfg_write    = 1'b0;
	logic                     cfg_index    = CFG_ON_LIMIT;
	logic [TICK_W-1:0]        cfg_data     = '0;
	logic                     busy;
	logic                     done;
	logic                     heater_on;
	logic                     in_band;
	logic [NUM_W-1:0]         current_index;
	logic                     awaiting;
	logic                     finished;
	logic                     active;
	logic [1:0]               status;
	int unsigned              fault_count;
	int unsigned              words_due;

	// target temperatures the table should hold, kept to aim the measurements
	logic [TEMP_W-1:0] table_temps[$];
	int unsigned       phase_words = 0;
	bit                gaps_on     = 1'b1;
	int unsigned       quiet       = 0;

	temperature_profile_sequencer DUT (.*);

	temperature_profile_sequencer_checker u_checker (.*);

	always #1 clk = ~clk;

	// Watchdog: count cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("temperature_profile_sequencer_test failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Drive one command word at the falling edge, idling first now and then, and
	// hold it until a rising edge takes it.
	task automatic send_word(word_t w);
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			@(negedge clk);
		end
		cmd          <= w.op;
		step_number  <= w.num;
		step_temp    <= w.deg;
		step_minutes <= w.mins;
		step_wait    <= w.ask;
		step_hold    <= w.drop;
		temperature  <= w.meas;
		elapsed_ms   <= w.ms;
		confirm      <= w.yes;
		start        <= 1'b1;
		do @(posedge clk); while (busy);
		phase_words++;
		// follow the table size so later targets and step numbers stay plausible
		case (w.op)
			CMD_ADD:    if (table_temps.size() < STEP_DEPTH_DEF) table_temps.push_back(w.deg);
			CMD_DELETE: if (table_temps.size() > 0) void'(table_temps.pop_back());
			CMD_UPDATE: if (w.num >= 1 && w.num <= table_temps.size())
				table_temps[w.num-1] = w.deg;
			default: ;
		endcase
	endtask

	// Drop start and hold off until every readout owed has come back.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (words_due != 0)
			@(negedge clk);
	endtask

	// Write both limits while the block is idle.
	task automatic set_limits(logic [TICK_W-1:0] on_lim, logic [TICK_W-1:0] off_lim);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_ON_LIMIT;
		cfg_data  <= on_lim;
		@(negedge clk);
		cfg_index <= CFG_OFF_LIMIT;
		cfg_data  <= off_lim;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic word_t random_word();
		word_t w;
		w.op   = 3'($urandom_range(0, 5));
		w.num  = NUM_W'($urandom_range(0, 31));
		w.deg  = TEMP_W'($urandom_range(0, 127));
		w.mins = MIN_W'($urandom_range(0, 65535));
		w.ask  = 1'($urandom_range(0, 1));
		w.drop = 1'($urandom_range(0, 1));
		w.meas = MEAS_W'(int'($urandom_range(0, 2880)) - 880);
		w.ms   = ELAPSED_W'($urandom_range(0, 65535));
		w.yes  = 1'($urandom_range(0, 1));
		return w;
	endfunction

	// Measurement mostly a little below to well inside the band of some step.
	function automatic logic signed [MEAS_W-1:0] aimed_meas();
		int tgt;
		int m;
		if (table_temps.size() == 0 || $urandom_range(0, 9) == 0)
			return MEAS_W'(int'($urandom_range(0, 2880)) - 880);
		tgt = table_temps[$urandom_range(0, table_temps.size() - 1)];
		m   = tgt * 16 + int'($urandom_range(0, 12 * 16)) - 2 * 16;
		if (m > 2000)
			m = 2000;
		return MEAS_W'(m);
	endfunction

	// One well-formed profile: trim the table, append steps, start, then tick it
	// along with the odd stray command thrown in.
	task automatic run_profile();
		word_t       w;
		int unsigned n_del;
		int unsigned n_add;
		int unsigned n_tick;
		int unsigned pick;
		n_del = ($urandom_range(0, 9) == 0) ? STEP_DEPTH_DEF + 1 : $urandom_range(0, 3);
		n_add = ($urandom_range(0, 11) == 0) ? STEP_DEPTH_DEF + 1 : $urandom_range(1, 6);
		repeat (n_del) begin
			w    = random_word();
			w.op = CMD_DELETE;
			send_word(w);
		end
		repeat (n_add) begin
			w     = random_word();
			w.op  = CMD_ADD;
			pick  = $urandom_range(0, 9);
			w.deg = TEMP_W'((pick == 0) ? $urandom_range(0, 127) : $urandom_range(18, 30));
			pick  = $urandom_range(0, 19);
			if (pick < 13)
				w.mins = '0;
			else if (pick < 18)
				w.mins = MIN_W'(1);
			else if (pick == 18)
				w.mins = '1;
			send_word(w);
		end
		w      = random_word();
		w.op   = CMD_GOTO;
		w.meas = aimed_meas();
		if ($urandom_range(0, 7) != 0)
			w.num = NUM_W'($urandom_range(1,
				(table_temps.size() > 0) ? table_temps.size() : 1));
		send_word(w);
		n_tick = $urandom_range(8, 30);
		repeat (n_tick) begin
			w = random_word();
			if ($urandom_range(0, 9) != 0) begin
				w.op   = CMD_TICK;
				w.meas = aimed_meas();
				w.yes  = ($urandom_range(0, 9) < 3);
				if ($urandom_range(0, 15) == 0)
					w.ms = '0;
			end else if (w.op == CMD_UPDATE && table_temps.size() > 0) begin
				w.num = NUM_W'($urandom_range(1, table_temps.size()));
				w.deg = TEMP_W'($urandom_range(18, 30));
			end
			send_word(w);
		end
	endtask

	initial begin
		logic [TICK_W-1:0] on_set [NUM_PHASES];
		logic [TICK_W-1:0] off_set[NUM_PHASES];
		on_set  = '{8'd0, 8'd255, 8'd1, 8'd255, 8'd3, 8'd0};
		off_set = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd8, 8'd0};
		on_set[5]  = TICK_W'($urandom_range(0, 255));
		off_set[5] = TICK_W'($urandom_range(0, 255));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset limits.
		// empty table: tick idles, delete / update / start all report empty
		send_word('{CMD_TICK,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, -12'sd880, 16'hFFFF, 1'b1});
		send_word('{CMD_DELETE, 5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		send_word('{CMD_UPDATE, 5'd1,  7'd5,   16'd1,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		send_word('{CMD_GOTO,   5'd1,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		send_word('{CMD_HALT,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		// three steps: zero target, extreme step, confirm-and-drop step
		send_word('{CMD_ADD,    5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		send_word('{CMD_ADD,    5'd31, 7'd127, 16'hFFFF,  1'b1, 1'b1, 12'sd0,    16'd0,    1'b0});
		send_word('{CMD_ADD,    5'd0,  7'd50,  16'd0,     1'b1, 1'b1, 12'sd0,    16'd0,    1'b0});
		// out-of-range updates, then a good one
		send_word('{CMD_UPDATE, 5'd0,  7'd9,   16'd9,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		send_word('{CMD_UPDATE, 5'd31, 7'd9,   16'd9,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		send_word('{CMD_UPDATE, 5'd2,  7'd20,  16'd0,     1'b1, 1'b1, 12'sd0,    16'd0,    1'b0});
		// out-of-range starts
		send_word('{CMD_GOTO,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		send_word('{CMD_GOTO,   5'd17, 7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		// start on zero target at minus one degree: in band, step done at once
		send_word('{CMD_GOTO,   5'd1,  7'd0,   16'd0,     1'b0, 1'b0, -12'sd16,  16'd1,    1'b0});
		// hold time passes on step two and it waits for a confirm
		send_word('{CMD_TICK,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd320,  16'd5,    1'b0});
		// dropped target while waiting; the third tick runs into the on limit
		send_word('{CMD_TICK,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd7,    1'b0});
		send_word('{CMD_TICK,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd7,    1'b0});
		// confirm during the hold wait moves on cleanly
		send_word('{CMD_TICK,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd7,    1'b1});
		send_word('{CMD_TICK,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd2000, 16'd9,    1'b0});
		// confirm given with the hold time: last step ends the profile
		send_word('{CMD_TICK,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd800,  16'hFFFF, 1'b1});
		send_word('{CMD_TICK,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd800,  16'd3,    1'b0});
		// unused codes are ignored
		send_word('{3'd6,       5'd1,  7'd1,   16'd1,     1'b1, 1'b1, 12'sd0,    16'd1,    1'b1});
		send_word('{3'd7,       5'd1,  7'd1,   16'd1,     1'b1, 1'b1, 12'sd0,    16'd1,    1'b1});
		// start part-way and stop
		send_word('{CMD_GOTO,   5'd3,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd790,  16'd2,    1'b0});
		send_word('{CMD_HALT,   5'd0,  7'd0,   16'd0,     1'b0, 1'b0, 12'sd0,    16'd0,    1'b0});
		drain();

		// Random phases, each under its own limits; the third runs without gaps.
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_limits(on_set[p], off_set[p]);
			gaps_on     = (p != 2);
			phase_words = 0;
			while (phase_words < PHASE_WORDS)
				run_profile();
			drain();
		end

		// let any stray readout show before the verdict
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("temperature_profile_sequencer_test passed");
		else
			$display("temperature_profile_sequencer_test failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/tps_pkg.sv
rtl/core/tps_step_mem.sv
rtl/core/temperature_profile_sequencer.sv
tb/temperature_profile_sequencer_checker.sv
tb/temperature_profile_sequencer_test.sv
